[src/i4gsd_pkg.sv]
// Shared constants and types for the INT4 group-scaled row dot unit.
`timescale 1ns / 1ps

package i4gsd_pkg;

    localparam int ACC_BITS   = 48;
    localparam int SCALE_BITS = 16;

    localparam int NIB_BITS   = 4;
    localparam int ACT_BITS   = 8;
    localparam int WBYTE_BITS = 8;
    localparam int SFIELD_BITS = 16;
    localparam int OUT_BITS   = 48;

    // nibble times activation, then times scale
    localparam int QA_BITS    = NIB_BITS + ACT_BITS;
    localparam int PROD_BITS  = QA_BITS + SCALE_BITS;
    // headroom for two products added onto the accumulator
    localparam int EXT_BITS   = ACC_BITS + 2;

    localparam int IN_TDATA_BITS  = 56;
    localparam int OUT_TDATA_BITS = 48;

    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

endpackage

[src/i4gsd_lane.sv]
// One weight lane: signed nibble times activation, then times the group scale.
`timescale 1ns / 1ps

module i4gsd_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   use_lane,
    input  logic [i4gsd_pkg::NIB_BITS-1:0]         nibble,
    input  logic [i4gsd_pkg::ACT_BITS-1:0]         act,
    input  logic [i4gsd_pkg::SFIELD_BITS-1:0]      scale,
    output logic signed [i4gsd_pkg::PROD_BITS-1:0] product
);
    import i4gsd_pkg::*;

    logic signed [NIB_BITS-1:0]   nib_s;
    logic signed [ACT_BITS-1:0]   act_s;
    logic signed [QA_BITS-1:0]    nib_x;
    logic signed [QA_BITS-1:0]    act_x;
    logic signed [QA_BITS-1:0]    qa_next;
    logic signed [QA_BITS-1:0]    qa_reg;
    logic signed [SCALE_BITS-1:0] sc_next;
    logic signed [SCALE_BITS-1:0] sc_reg;
    logic signed [PROD_BITS-1:0]  qa_w;
    logic signed [PROD_BITS-1:0]  sc_w;
    logic signed [PROD_BITS-1:0]  prod_next;
    logic signed [PROD_BITS-1:0]  prod_reg;

    assign nib_s = $signed(nibble);
    assign act_s = $signed(act);
    assign nib_x = QA_BITS'(nib_s);
    assign act_x = QA_BITS'(act_s);

    // an unused column contributes zero
    assign qa_next = use_lane ? (nib_x * act_x) : '0;
    assign sc_next = $signed(scale[SCALE_BITS-1:0]);

    assign qa_w      = PROD_BITS'(qa_reg);
    assign sc_w      = PROD_BITS'(sc_reg);
    assign prod_next = qa_w * sc_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg   <= qa_next;
            sc_reg   <= sc_next;
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

[src/i4gsd_merge.sv]
// Merge stage: saturating row accumulator fed by both lanes, plus the result register.
`timescale 1ns / 1ps

module i4gsd_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  i4gsd_pkg::pipe_ctl_t                   ctl,
    input  logic signed [i4gsd_pkg::PROD_BITS-1:0] prod_low,
    input  logic signed [i4gsd_pkg::PROD_BITS-1:0] prod_high,
    input  logic                                   out_ready,
    output logic                                   en,
    output logic                                   out_valid,
    output logic [i4gsd_pkg::OUT_BITS-1:0]         out_sum,
    output logic                                   out_sat
);
    import i4gsd_pkg::*;

    localparam logic signed [EXT_BITS-1:0] ACC_MAX_EXT =
        (EXT_BITS'(1) <<< (ACC_BITS - 1)) - EXT_BITS'(1);
    localparam logic signed [EXT_BITS-1:0] ACC_MIN_EXT = ~ACC_MAX_EXT;

    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic                       clip_reg;
    logic                       clip_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [OUT_BITS-1:0]        sum_reg;
    logic [OUT_BITS-1:0]        sum_next;
    logic                       sat_reg;
    logic                       sat_next;

    logic                       fire;
    logic signed [EXT_BITS-1:0] acc_x;
    logic signed [EXT_BITS-1:0] p0_x;
    logic signed [EXT_BITS-1:0] p1_x;
    logic signed [EXT_BITS-1:0] t0;
    logic signed [EXT_BITS-1:0] t01;
    logic signed [EXT_BITS-1:0] max_p1;
    logic signed [EXT_BITS-1:0] min_p1;
    logic signed [EXT_BITS-1:0] r;
    logic                       clip_now;

    // hold the pipe only when a row result cannot be handed over
    assign en   = !ctl.valid || !ctl.last || !out_valid_reg || out_ready;
    assign fire = en && ctl.valid;

    assign acc_x  = EXT_BITS'(acc_reg);
    assign p0_x   = EXT_BITS'(prod_low);
    assign p1_x   = EXT_BITS'(prod_high);
    assign t0     = acc_x + p0_x;
    assign t01    = t0 + p1_x;
    assign max_p1 = ACC_MAX_EXT + p1_x;
    assign min_p1 = ACC_MIN_EXT + p1_x;

    // low column clips first, then the high column adds onto the clipped value
    always_comb
    begin
        r        = t01;
        clip_now = 1'b0;
        if (t0 > ACC_MAX_EXT)
        begin
            clip_now = 1'b1;
            r        = (p1_x > 0) ? ACC_MAX_EXT : max_p1;
        end
        else if (t0 < ACC_MIN_EXT)
        begin
            clip_now = 1'b1;
            r        = (p1_x < 0) ? ACC_MIN_EXT : min_p1;
        end
        else if (t01 > ACC_MAX_EXT)
        begin
            clip_now = 1'b1;
            r        = ACC_MAX_EXT;
        end
        else if (t01 < ACC_MIN_EXT)
        begin
            clip_now = 1'b1;
            r        = ACC_MIN_EXT;
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            if (ctl.last)
            begin
                acc_next       = '0;
                clip_next      = 1'b0;
                out_valid_next = 1'b1;
                sum_next       = OUT_BITS'(r);
                sat_next       = clip_reg | clip_now;
            end
            else
            begin
                acc_next  = r[ACC_BITS-1:0];
                clip_next = clip_reg | clip_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sat_reg <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = sum_reg;
    assign out_sat   = sat_reg;

endmodule

[src/int4_group_scaled_row_dot_unit.sv]
// Top level of the INT4 group-scaled row dot unit.
// Usage:
//   The slave stream takes one beat per packed weight byte of a matrix row:
//   tdata carries the two signed 4-bit weights, their INT8 activations and
//   their signed Q3.12 group scales; tuser says whether the high nibble is a
//   real column; tlast marks the final byte of the row.
//   The master stream gives one beat per row: tdata is the 48-bit saturated
//   dot product with 12 fraction bits, tuser flags that the row clipped.
//   Throughput is one beat per cycle unless a held result stalls the pipe:
//   two weight lanes multiply in parallel over two stages, and the merge
//   stage folds both products into the accumulator in one saturating add.
//   A row result shows on the master side once its last beat has passed
//   the register of each lane stage and then the merge register.
//   Reset clears the accumulator, the clip flag and the result valid flag.
//   When the receiver stalls, the held result stays put and the block keeps
//   taking beats until another row end reaches the merge stage; then the
//   whole pipe holds and tready drops until the result is taken.
`timescale 1ns / 1ps

module int4_group_scaled_row_dot_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // weight_byte, act_low, act_high, scale_low, scale_high (low bit up)
    input  logic [i4gsd_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
    // high_valid
    input  logic                                     s_axis_tuser,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // row_sum
    output logic [i4gsd_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    // saturated
    output logic                                     m_axis_tuser
);
    import i4gsd_pkg::*;

    pipe_ctl_t                   ctl_a_reg;
    pipe_ctl_t                   ctl_a_next;
    pipe_ctl_t                   ctl_b_reg;
    logic                        en;
    logic signed [PROD_BITS-1:0] prod_low;
    logic signed [PROD_BITS-1:0] prod_high;
    logic [OUT_BITS-1:0]         out_sum;

    assign s_axis_tready = en;

    assign ctl_a_next.valid = s_axis_tvalid;
    assign ctl_a_next.last  = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    i4gsd_lane u_lane_low (
        .clk      (clk),
        .en       (en),
        .use_lane (1'b1),
        .nibble   (s_axis_tdata[3:0]),
        .act      (s_axis_tdata[15:8]),
        .scale    (s_axis_tdata[39:24]),
        .product  (prod_low)
    );

    i4gsd_lane u_lane_high (
        .clk      (clk),
        .en       (en),
        .use_lane (s_axis_tuser),
        .nibble   (s_axis_tdata[7:4]),
        .act      (s_axis_tdata[23:16]),
        .scale    (s_axis_tdata[55:40]),
        .product  (prod_high)
    );

    i4gsd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_b_reg),
        .prod_low  (prod_low),
        .prod_high (prod_high),
        .out_ready (m_axis_tready),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_sum   (out_sum),
        .out_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(out_sum);

endmodule
